>>> sv/fbm_pkg.sv
// Shared types and constants of the firmware bank mapper with SRAM port.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package fbm_pkg;

   localparam int SRAM_BYTES  = 4096;
   localparam int SRAM_AW     = $clog2(SRAM_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] ADDR_CONTROL       = 16'h7ff9;
   localparam logic [15:0] ADDR_BANK1_WR      = 16'h6000;
   localparam logic [15:0] ADDR_BANK0_WR      = 16'h6400;
   localparam logic [15:0] ADDR_BANK2_WR      = 16'h7000;
   localparam logic [15:0] ADDR_BANK_RD_FIRST = 16'h7ff0;
   localparam logic [15:0] ADDR_BANK_RD_LAST  = 16'h7ff5;
   localparam logic [13:0] LO_PORT_FIRST      = 14'h3ffa;
   localparam logic [13:0] LO_PORT_LAST       = 14'h3ffd;

   localparam logic [1:0] PAGE_MIDDLE = 2'd1;
   localparam logic [1:0] PAGE_UNMAPPED = 2'd3;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_ROM  = 2'd1,
      KIND_BANK = 2'd2,
      KIND_SRAM = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SOP_NONE  = 2'd0,
      SOP_READ  = 2'd1,
      SOP_WRITE = 2'd2
   } sram_op_type;

   typedef enum logic [1:0] {
      PORT_PTR_HIGH = 2'd0,
      PORT_PTR_MID  = 2'd1,
      PORT_PTR_LOW  = 2'd2,
      PORT_DATA     = 2'd3
   } port_type;

   typedef struct packed {
      kind_type           kind;
      sram_op_type        sop;
      logic [SRAM_AW-1:0] sram_index;
      logic [7:0]         data;
      logic [19:0]        page_addr;
   } op_type;

endpackage
`default_nettype wire

>>> sv/fbm_front.sv
// Front end: accepts bus accesses, keeps the bank, view and pointer registers
// and classifies each item into an operation for the back end. Uses fbm_pkg.
`default_nettype none
module fbm_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_type,
   input  wire logic [15:0]     req_bus_address,
   input  wire logic [7:0]      req_write_data,
   input  wire logic            clear_busy,
   input  wire logic            push_ready,
   output logic                 push_valid,
   output fbm_pkg::op_type      push_op
);

   logic [5:0]  bank0_ff, bank0_in;
   logic [5:0]  bank1_ff, bank1_in;
   logic [5:0]  bank2_ff, bank2_in;
   logic        view_low_ff, view_low_in;
   logic [1:0]  view_mid_ff, view_mid_in;
   logic [23:0] pointer_ff, pointer_in;

   logic [1:0]        page;
   logic [13:0]       lo;
   logic [13:0]       port_offset;
   logic              sram_vis;
   logic              in_port;
   logic              accept;
   fbm_pkg::port_type port;
   fbm_pkg::op_type   op;

   function automatic logic [5:0] pick_bank(input logic [1:0] sel, input logic [5:0] b0,
                                            input logic [5:0] b1, input logic [5:0] b2);
      logic [5:0] r;
      case (sel)
         2'd0:    r = b0;
         2'd1:    r = b1;
         2'd2:    r = b2;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign req_ready  = push_ready && !clear_busy;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept;
   assign push_op    = op;

   always_comb begin
      page        = req_bus_address[15:14];
      lo          = req_bus_address[13:0];
      port_offset = lo - fbm_pkg::LO_PORT_FIRST;
      port        = fbm_pkg::port_type'(port_offset[1:0]);
      sram_vis    = (page == fbm_pkg::PAGE_MIDDLE) ? view_mid_ff[0] : view_low_ff;
      in_port     = (page != fbm_pkg::PAGE_UNMAPPED) && sram_vis &&
                    (lo >= fbm_pkg::LO_PORT_FIRST) && (lo <= fbm_pkg::LO_PORT_LAST);

      bank0_in    = bank0_ff;
      bank1_in    = bank1_ff;
      bank2_in    = bank2_ff;
      view_low_in = view_low_ff;
      view_mid_in = view_mid_ff;
      pointer_in  = pointer_ff;

      op            = '0;
      op.kind       = fbm_pkg::KIND_NONE;
      op.sop        = fbm_pkg::SOP_NONE;
      op.sram_index = pointer_ff[fbm_pkg::SRAM_AW-1:0];

      if (req_type) begin
         if (req_bus_address == fbm_pkg::ADDR_CONTROL) begin
            view_low_in = req_write_data[1];
            view_mid_in = req_write_data[2:1];
         end else if (in_port) begin
            unique case (port)
               fbm_pkg::PORT_PTR_HIGH: pointer_in[23:16] = req_write_data;
               fbm_pkg::PORT_PTR_MID:  pointer_in[15:8]  = req_write_data;
               fbm_pkg::PORT_PTR_LOW:  pointer_in[7:0]   = req_write_data;
               fbm_pkg::PORT_DATA: begin
                  op.sop     = fbm_pkg::SOP_WRITE;
                  op.data    = req_write_data;
                  pointer_in = pointer_ff + 24'd1;
               end
               default: ;
            endcase
         end else if (page == fbm_pkg::PAGE_MIDDLE && !view_mid_ff[0]) begin
            if (req_bus_address == fbm_pkg::ADDR_BANK1_WR) begin
               bank1_in = req_write_data[5:0];
            end else if (req_bus_address == fbm_pkg::ADDR_BANK0_WR) begin
               bank0_in = req_write_data[5:0];
            end else if (req_bus_address == fbm_pkg::ADDR_BANK2_WR) begin
               bank2_in = req_write_data[5:0];
            end
         end
      end else if (page != fbm_pkg::PAGE_UNMAPPED) begin
         if (sram_vis && lo == fbm_pkg::LO_PORT_LAST) begin
            op.kind    = fbm_pkg::KIND_SRAM;
            op.sop     = fbm_pkg::SOP_READ;
            pointer_in = pointer_ff + 24'd1;
         end else if (page == fbm_pkg::PAGE_MIDDLE && view_mid_ff[1] &&
                      req_bus_address >= fbm_pkg::ADDR_BANK_RD_FIRST &&
                      req_bus_address <= fbm_pkg::ADDR_BANK_RD_LAST) begin
            op.kind = fbm_pkg::KIND_BANK;
            op.data = {2'b00, pick_bank(req_bus_address[2:1], bank0_ff, bank1_ff, bank2_ff)};
         end else begin
            op.kind      = fbm_pkg::KIND_ROM;
            op.page_addr = {pick_bank(page, bank0_ff, bank1_ff, bank2_ff), lo};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank0_ff    <= '0;
         bank1_ff    <= '0;
         bank2_ff    <= '0;
         view_low_ff <= 1'b0;
         view_mid_ff <= '0;
         pointer_ff  <= '0;
      end else if (accept) begin
         bank0_ff    <= bank0_in;
         bank1_ff    <= bank1_in;
         bank2_ff    <= bank2_in;
         view_low_ff <= view_low_in;
         view_mid_ff <= view_mid_in;
         pointer_ff  <= pointer_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/fbm_queue.sv
// Short operation queue between the front end and the back end.
// Uses fbm_pkg for the operation type and the depth.
`default_nettype none
module fbm_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   output logic                 push_ready,
   input  wire fbm_pkg::op_type push_op,
   output logic                 pop_valid,
   input  wire logic            pop,
   output fbm_pkg::op_type      pop_op
);

   fbm_pkg::op_type                 entry_ff [fbm_pkg::QUEUE_DEPTH];
   logic [fbm_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [fbm_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [fbm_pkg::QUEUE_CW-1:0]    count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   function automatic logic [fbm_pkg::QUEUE_AW-1:0] next_ptr(
      input logic [fbm_pkg::QUEUE_AW-1:0] p);
      logic [fbm_pkg::QUEUE_AW-1:0] r;
      if (p == fbm_pkg::QUEUE_AW'(fbm_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign push_ready = count_ff != fbm_pkg::QUEUE_CW'(fbm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

>>> sv/fbm_back.sv
// Back end: SRAM store with its clearing pass, ROM address adder and the
// result register. Uses fbm_pkg.
`default_nettype none
module fbm_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [23:0]     rom_base_offset,
   input  wire logic            pop_valid,
   input  wire fbm_pkg::op_type pop_op,
   output logic                 pop,
   output logic                 clear_busy,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [1:0]           rsp_result_kind,
   output logic [7:0]           rsp_read_data,
   output logic [23:0]          rsp_rom_address
);

   logic [7:0]                  sram_mem [fbm_pkg::SRAM_BYTES];
   logic [7:0]                  sram_rd_ff;
   logic                        clear_ff;
   logic [fbm_pkg::SRAM_AW-1:0] clear_addr_ff;
   logic                        out_valid_ff;
   fbm_pkg::kind_type           kind_ff;
   logic [7:0]                  data_ff;
   logic [23:0]                 rom_ff;

   logic                        mem_we;
   logic [fbm_pkg::SRAM_AW-1:0] mem_addr;
   logic [7:0]                  mem_wdata;
   logic                        mem_re;

   assign clear_busy = clear_ff;
   assign pop        = pop_valid && !clear_ff && (!out_valid_ff || rsp_ready);
   assign mem_we     = clear_ff || (pop && pop_op.sop == fbm_pkg::SOP_WRITE);
   assign mem_addr   = clear_ff ? clear_addr_ff : pop_op.sram_index;
   assign mem_wdata  = clear_ff ? 8'h00 : pop_op.data;
   assign mem_re     = pop && pop_op.sop == fbm_pkg::SOP_READ;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == '1) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sram_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         sram_rd_ff <= sram_mem[pop_op.sram_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         kind_ff      <= fbm_pkg::KIND_NONE;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
         kind_ff      <= pop_op.kind;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_op.data;
         rom_ff  <= rom_base_offset + {4'h0, pop_op.page_addr};
      end
   end

   always_comb begin
      rsp_valid       = out_valid_ff;
      rsp_result_kind = kind_ff;
      rsp_read_data   = '0;
      rsp_rom_address = '0;
      case (kind_ff)
         fbm_pkg::KIND_ROM:  rsp_rom_address = rom_ff;
         fbm_pkg::KIND_BANK: rsp_read_data   = data_ff;
         fbm_pkg::KIND_SRAM: rsp_read_data   = sram_rd_ff;
         default: ;
      endcase
   end

   a_no_pop_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !pop)
      else $error("operation taken during SRAM clearing pass");

   a_sram_read_kind : assert property (@(posedge clock) disable iff (reset)
      pop && pop_op.kind == fbm_pkg::KIND_SRAM |-> pop_op.sop == fbm_pkg::SOP_READ)
      else $error("SRAM read result without an SRAM read");

   a_pop_gives_result : assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("taken operation produced no result");

   a_result_not_dropped : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !pop)
      else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

>>> sv/firmware_bank_mapper_with_sram_port_unit.sv
// Top level of the firmware bank mapper with SRAM port: ROM offset register,
// front end, operation queue and back end. Uses fbm_pkg, fbm_front,
// fbm_queue and fbm_back.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_ready  req_type, req_bus_address, req_write_data
//   rsp      out        rsp_valid/rsp_ready  rsp_result_kind, rsp_read_data, rsp_rom_address
//   csr      in         csr_we               csr_wdata (ROM base offset)
//
// One item is accepted per cycle while the queue has room and no SRAM clearing pass runs;
// with an empty queue its result passes the queue entry and the result register in turn.
// After reset the SRAM is cleared one byte a cycle, all 4096 bytes, while no item is taken.
// A stalled result holds the back end; the queue absorbs two further items.
`default_nettype none
module firmware_bank_mapper_with_sram_port_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_read_data,
   output logic [23:0]      rsp_rom_address
);

   logic [23:0]     rom_base_offset_ff;
   logic            clear_busy;
   logic            push_valid;
   logic            push_ready;
   fbm_pkg::op_type push_op;
   logic            pop_valid;
   logic            pop;
   fbm_pkg::op_type pop_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_base_offset_ff <= '0;
      end else if (csr_we) begin
         rom_base_offset_ff <= csr_wdata;
      end
   end

   fbm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_bus_address (req_bus_address),
      .req_write_data  (req_write_data),
      .clear_busy      (clear_busy),
      .push_ready      (push_ready),
      .push_valid      (push_valid),
      .push_op         (push_op)
   );

   fbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_op     (pop_op)
   );

   fbm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rom_base_offset (rom_base_offset_ff),
      .pop_valid       (pop_valid),
      .pop_op          (pop_op),
      .pop             (pop),
      .clear_busy      (clear_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_rom_address (rsp_rom_address)
   );

endmodule
`default_nettype wire
